>>> design/lms_pkg.sv
// lms_pkg: shared widths, register indexes, state and operation codes
// for the lms adaptive filter; no dependencies
`default_nettype none

package lms_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 32;
    localparam int STEP_W       = 16;
    localparam int TAPS_W       = 9;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int EST_SHIFT    = 30;
    localparam int ERR_LIMIT    = 32767;
    localparam int STEP_RESET   = 1966;
    localparam int TAPS_RESET   = 256;
    localparam int DEF_MAX_TAPS = 256;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS_IN_USE = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILTER,
        ST_ROUND,
        ST_DIFF,
        ST_POST,
        ST_SCALE,
        ST_UPDATE
    } st_t;

    typedef enum logic [1:0] {
        OP_FILTER,
        OP_SCALE,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic clear;
        logic acc_clr;
        logic acc_en;
        logic est_en;
        logic err_en;
        logic out_load;
        logic se_en;
        logic mic_load;
    } ctl_t;

endpackage

`default_nettype wire

>>> design/lms_if.sv
// lms_if: valid/ready channel interfaces for sample words and error words
// depends on lms_pkg
`default_nettype none

interface lms_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lms_pkg::SAMPLE_W-1:0]  mic_sample;
    logic signed [lms_pkg::SAMPLE_W-1:0]  ref_sample;

    modport source (output valid, output mic_sample, output ref_sample, input ready);
    modport sink   (input valid, input mic_sample, input ref_sample, output ready);
endinterface

interface lms_error_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [lms_pkg::SAMPLE_W-1:0]  error_out;

    modport source (output valid, output error_out, input ready);
    modport sink   (input valid, input error_out, output ready);
endinterface

`default_nettype wire

>>> design/lms_ram.sv
// lms_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lms_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/lms_mac.sv
// lms_mac: shared multiplier with accumulate, rounding, error and coefficient update
// depends on lms_pkg; driven by lms_seq through lms_pkg::ctl_t
`default_nettype none

module lms_mac #(
    parameter int  MAX_TAPS = lms_pkg::DEF_MAX_TAPS,
    localparam int ACC_W    = lms_pkg::COEF_W + lms_pkg::SAMPLE_W + $clog2(MAX_TAPS),
    localparam int EST_W    = ACC_W - lms_pkg::EST_SHIFT + 1,
    localparam int ERR_W    = EST_W + 1,
    localparam int MUL_B_W  = lms_pkg::STEP_W + 1,
    localparam int MUL_A_W  = ERR_W + MUL_B_W,
    localparam int PROD_W   = MUL_A_W + MUL_B_W,
    localparam int DELTA_W  = PROD_W - lms_pkg::STEP_W + 1,
    localparam int SUM_W    = DELTA_W + 1
) (
    input  wire logic                                clk,
    input  wire lms_pkg::ctl_t                       ctl,
    input  wire logic [lms_pkg::STEP_W-1:0]          step_size,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0] mic_sample,
    input  wire logic signed [lms_pkg::SAMPLE_W-1:0] ref_sample,
    input  wire logic [lms_pkg::SAMPLE_W-1:0]        hist_rdata,
    input  wire logic [lms_pkg::COEF_W-1:0]          coef_rdata,
    output logic      [lms_pkg::SAMPLE_W-1:0]        hist_wdata,
    output logic      [lms_pkg::COEF_W-1:0]          coef_wdata,
    output logic signed [lms_pkg::SAMPLE_W-1:0]      error_out
);

    localparam int SW = lms_pkg::SAMPLE_W;
    localparam int CW = lms_pkg::COEF_W;

    localparam logic signed [ACC_W:0]  EST_HALF   = (ACC_W+1)'(2**(lms_pkg::EST_SHIFT-1));
    localparam logic signed [PROD_W:0] DELTA_HALF = (PROD_W+1)'(2**(lms_pkg::STEP_W-1));
    localparam logic signed [ERR_W-1:0] ERR_POS   = ERR_W'(lms_pkg::ERR_LIMIT);
    localparam logic signed [ERR_W-1:0] ERR_NEG   = -ERR_POS;
    localparam logic signed [SW-1:0]    OUT_POS   = SW'(lms_pkg::ERR_LIMIT);
    localparam logic signed [SW-1:0]    OUT_NEG   = -OUT_POS;
    localparam logic [CW-1:0]           COEF_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]           COEF_MIN  = {1'b1, {(CW-1){1'b0}}};

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [EST_W-1:0]   est_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [MUL_A_W-1:0] se_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [CW-1:0]             coef_d_reg [2];
    logic signed [SW-1:0]      mic_reg;
    logic signed [SW-1:0]      out_reg;

    logic [ACC_W:0]            acc_round;
    logic [PROD_W:0]           prod_round;
    logic [SUM_W-1:0]          coef_sum;
    logic [SUM_W-CW:0]         sum_high;
    logic                      sum_ovf;
    logic [CW-1:0]             coef_sat;
    logic signed [SW-1:0]      err_sat;

    // shared multiplier operand select
    always_comb
    begin
        unique case (ctl.op)
            lms_pkg::OP_SCALE:
            begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {1'b0, step_size};
            end
            lms_pkg::OP_UPDATE:
            begin
                mul_a = se_reg;
                mul_b = {hist_rdata[SW-1], hist_rdata};
            end
            default:
            begin
                mul_a = {{(MUL_A_W-CW){coef_rdata[CW-1]}}, coef_rdata};
                mul_b = {hist_rdata[SW-1], hist_rdata};
            end
        endcase
    end

    assign acc_round  = {acc_reg[ACC_W-1], acc_reg} + EST_HALF;
    assign prod_round = {prod_reg[PROD_W-1], prod_reg} + DELTA_HALF;

    // coefficient plus delta, clamped to the signed 32-bit range
    assign coef_sum = {{(SUM_W-CW){coef_d_reg[1][CW-1]}}, coef_d_reg[1]}
                    + {delta_reg[DELTA_W-1], delta_reg};
    assign sum_high = coef_sum[SUM_W-1:CW-1];
    assign sum_ovf  = !((&sum_high) || !(|sum_high));
    assign coef_sat = sum_ovf ? (coef_sum[SUM_W-1] ? COEF_MIN : COEF_MAX)
                              : coef_sum[CW-1:0];

    always_comb
    begin
        if (err_reg > ERR_POS)
        begin
            err_sat = OUT_POS;
        end
        else if (err_reg < ERR_NEG)
        begin
            err_sat = OUT_NEG;
        end
        else
        begin
            err_sat = err_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= mul_a * mul_b;
        delta_reg     <= prod_round[PROD_W:lms_pkg::STEP_W];
        coef_d_reg[0] <= coef_rdata;
        coef_d_reg[1] <= coef_d_reg[0];
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
        end
        if (ctl.mic_load)
        begin
            mic_reg <= mic_sample;
        end
        if (ctl.est_en)
        begin
            est_reg <= acc_round[ACC_W:lms_pkg::EST_SHIFT];
        end
        if (ctl.err_en)
        begin
            err_reg <= {{(ERR_W-SW){mic_reg[SW-1]}}, mic_reg}
                     - {est_reg[EST_W-1], est_reg};
        end
        if (ctl.se_en)
        begin
            se_reg <= prod_reg[MUL_A_W-1:0];
        end
        if (ctl.out_load)
        begin
            out_reg <= err_sat;
        end
    end

    assign hist_wdata = ctl.clear ? '0 : ref_sample;
    assign coef_wdata = ctl.clear ? '0 : coef_sat;
    assign error_out  = out_reg;

endmodule

`default_nettype wire

>>> design/lms_seq.sv
// lms_seq: sequencer, tap counter, history pointer and configuration registers
// depends on lms_pkg; controls lms_mac and both lms_ram instances
`default_nettype none

module lms_seq #(
    parameter int  MAX_TAPS = lms_pkg::DEF_MAX_TAPS,
    localparam int ADDR_W   = $clog2(MAX_TAPS),
    localparam int CNT_W    = $clog2(MAX_TAPS + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [lms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lms_pkg::STEP_W-1:0]             step_size,
    output lms_pkg::ctl_t                          ctl,
    output logic                                   hist_we,
    output logic [ADDR_W-1:0]                      hist_waddr,
    output logic [ADDR_W-1:0]                      hist_raddr,
    output logic                                   coef_we,
    output logic [ADDR_W-1:0]                      coef_waddr,
    output logic [ADDR_W-1:0]                      coef_raddr
);

    localparam int CMP_W = (CNT_W > lms_pkg::TAPS_W) ? CNT_W : lms_pkg::TAPS_W;
    localparam logic [CMP_W-1:0]  TAPS_MAX_C = CMP_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0]  TAPS_RST   = (lms_pkg::TAPS_RESET > MAX_TAPS)
                                             ? CNT_W'(MAX_TAPS)
                                             : CNT_W'(lms_pkg::TAPS_RESET);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MAX_TAPS - 1);

    lms_pkg::st_t               state_reg, state_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [ADDR_W-1:0]          wp_reg, wp_next;
    logic [ADDR_W-1:0]          haddr_reg, haddr_next;
    logic [2:0]                 vld_reg, vld_next;
    logic                       out_valid_reg, out_valid_next;
    logic [lms_pkg::STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]           taps_reg, taps_next;
    logic [ADDR_W-1:0]          ka_reg [3];

    logic [CMP_W-1:0]           taps_raw;
    logic                       taps_wr;
    logic                       accept;
    logic                       issue;
    logic                       busy;
    logic                       out_free;
    logic [ADDR_W-1:0]          wp_inc;
    logic [ADDR_W-1:0]          haddr_dec;

    assign in_ready  = (state_reg == lms_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign issue     = ((state_reg == lms_pkg::ST_FILTER) || (state_reg == lms_pkg::ST_UPDATE))
                    && (k_reg < taps_reg);
    assign busy      = |vld_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign wp_inc    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + ADDR_W'(1);
    assign haddr_dec = (haddr_reg == '0) ? LAST_ADDR : haddr_reg - ADDR_W'(1);
    assign taps_raw  = CMP_W'(cfg_data[lms_pkg::TAPS_W-1:0]);

    // register write decode
    always_comb
    begin
        step_next = step_reg;
        taps_next = taps_reg;
        taps_wr   = 1'b0;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                lms_pkg::REG_STEP_SIZE:
                begin
                    step_next = cfg_data[lms_pkg::STEP_W-1:0];
                end
                lms_pkg::REG_TAPS_IN_USE:
                begin
                    taps_wr = 1'b1;
                    if (taps_raw == '0)
                    begin
                        taps_next = CNT_W'(1);
                    end
                    else if (taps_raw > TAPS_MAX_C)
                    begin
                        taps_next = CNT_W'(MAX_TAPS);
                    end
                    else
                    begin
                        taps_next = CNT_W'(taps_raw);
                    end
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lms_pkg::ST_CLEAR:
            begin
                if (k_reg == CNT_W'(MAX_TAPS - 1))
                begin
                    state_next = lms_pkg::ST_IDLE;
                end
            end
            lms_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lms_pkg::ST_FILTER;
                end
            end
            lms_pkg::ST_FILTER:
            begin
                if (!issue && !busy)
                begin
                    state_next = lms_pkg::ST_ROUND;
                end
            end
            lms_pkg::ST_ROUND:
            begin
                state_next = lms_pkg::ST_DIFF;
            end
            lms_pkg::ST_DIFF:
            begin
                state_next = lms_pkg::ST_POST;
            end
            lms_pkg::ST_POST:
            begin
                if (out_free)
                begin
                    state_next = lms_pkg::ST_SCALE;
                end
            end
            lms_pkg::ST_SCALE:
            begin
                state_next = lms_pkg::ST_UPDATE;
            end
            lms_pkg::ST_UPDATE:
            begin
                if (!issue && !busy)
                begin
                    state_next = lms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lms_pkg::ST_CLEAR;
            end
        endcase
        if (taps_wr)
        begin
            state_next = lms_pkg::ST_CLEAR;
        end
    end

    // datapath controls
    always_comb
    begin
        ctl          = '0;
        ctl.op       = lms_pkg::OP_FILTER;
        unique case (state_reg)
            lms_pkg::ST_CLEAR:
            begin
                ctl.clear = 1'b1;
            end
            lms_pkg::ST_ROUND:
            begin
                ctl.est_en = 1'b1;
            end
            lms_pkg::ST_DIFF:
            begin
                ctl.err_en = 1'b1;
            end
            lms_pkg::ST_POST:
            begin
                ctl.op       = lms_pkg::OP_SCALE;
                ctl.out_load = out_free;
            end
            lms_pkg::ST_SCALE:
            begin
                ctl.se_en = 1'b1;
            end
            lms_pkg::ST_UPDATE:
            begin
                ctl.op = lms_pkg::OP_UPDATE;
            end
            default:
            begin
                ctl.clear = 1'b0;
            end
        endcase
        ctl.acc_clr  = accept;
        ctl.mic_load = accept;
        ctl.acc_en   = vld_reg[1] && (state_reg == lms_pkg::ST_FILTER);
    end

    // counters, pointers and pipeline tracking
    always_comb
    begin
        k_next         = k_reg;
        wp_next        = wp_reg;
        haddr_next     = haddr_reg;
        vld_next       = {vld_reg[1:0], issue};
        out_valid_next = out_valid_reg;
        if (taps_wr)
        begin
            k_next = '0;
        end
        else if (state_reg == lms_pkg::ST_CLEAR)
        begin
            k_next = k_reg + CNT_W'(1);
        end
        else if (accept || (state_reg == lms_pkg::ST_SCALE))
        begin
            k_next = '0;
        end
        else if (issue)
        begin
            k_next = k_reg + CNT_W'(1);
        end
        if (accept)
        begin
            wp_next    = wp_inc;
            haddr_next = wp_inc;
        end
        else if (state_reg == lms_pkg::ST_SCALE)
        begin
            haddr_next = wp_reg;
        end
        else if (issue)
        begin
            haddr_next = haddr_dec;
        end
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lms_pkg::ST_CLEAR;
            k_reg         <= '0;
            wp_reg        <= '0;
            haddr_reg     <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= lms_pkg::STEP_W'(lms_pkg::STEP_RESET);
            taps_reg      <= TAPS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            wp_reg        <= wp_next;
            haddr_reg     <= haddr_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            taps_reg      <= taps_next;
        end
    end

    // write address follows the multiply pipeline
    always_ff @(posedge clk)
    begin
        ka_reg[0] <= k_reg[ADDR_W-1:0];
        ka_reg[1] <= ka_reg[0];
        ka_reg[2] <= ka_reg[1];
    end

    assign hist_we    = ctl.clear || accept;
    assign hist_waddr = ctl.clear ? k_reg[ADDR_W-1:0] : wp_inc;
    assign hist_raddr = haddr_reg;
    assign coef_we    = ctl.clear || (vld_reg[2] && (state_reg == lms_pkg::ST_UPDATE));
    assign coef_waddr = ctl.clear ? k_reg[ADDR_W-1:0] : ka_reg[2];
    assign coef_raddr = k_reg[ADDR_W-1:0];
    assign out_valid  = out_valid_reg;
    assign step_size  = step_reg;

`ifndef ASSERT_OFF
    a_coef_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        coef_we |-> ((state_reg == lms_pkg::ST_CLEAR) || (state_reg == lms_pkg::ST_UPDATE)))
        else $error("coefficient write outside clear or update");

    a_drained_at_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lms_pkg::ST_ROUND) |-> (vld_reg == 3'b000))
        else $error("filter pipeline not drained before rounding");

    a_tap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lms_pkg::ST_FILTER) || (state_reg == lms_pkg::ST_UPDATE))
        |-> (k_reg <= taps_reg))
        else $error("tap counter past active taps");

    a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
        (taps_reg != '0) && (taps_reg <= CNT_W'(MAX_TAPS)))
        else $error("tap count out of range");

    a_accept_starts_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !taps_wr) |=> (state_reg == lms_pkg::ST_FILTER))
        else $error("accepted word did not start the filter pass");
`endif

endmodule

`default_nettype wire

>>> design/lms_adaptive_filter.sv
// lms_adaptive_filter: top level of the lms adaptive fir echo canceller
// depends on lms_pkg, lms_if, lms_ram, lms_mac, lms_seq
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   mic_sample, ref_sample (q1.15)
//   errors    out  valid/ready   error_out (q1.15, saturated)
//   cfg       in   cfg_write_en  cfg_index, cfg_data (no read-back)
//
// each word takes a filter pass and an update pass,
// each one tap per cycle through the shared multiplier and its ram reads
// reset and every taps_in_use write start a clearing pass over all MAX_TAPS addresses
// of both rams; samples.ready stays low during it
// a finished error word sits in an output register; only when it is still
// unread as the next error word is ready does the sequencer wait
`default_nettype none

module lms_adaptive_filter #(
    parameter int  MAX_TAPS = lms_pkg::DEF_MAX_TAPS,
    localparam int ADDR_W   = $clog2(MAX_TAPS)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lms_sample_if.sink                          samples,
    lms_error_if.source                         errors,
    input  wire logic                           cfg_write_en,
    input  wire logic [lms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lms_pkg::CFG_DATA_W-1:0] cfg_data
);

    lms_pkg::ctl_t                ctl;
    logic [lms_pkg::STEP_W-1:0]   step_size;
    logic                         hist_we;
    logic [ADDR_W-1:0]            hist_waddr;
    logic [ADDR_W-1:0]            hist_raddr;
    logic [lms_pkg::SAMPLE_W-1:0] hist_wdata;
    logic [lms_pkg::SAMPLE_W-1:0] hist_rdata;
    logic                         coef_we;
    logic [ADDR_W-1:0]            coef_waddr;
    logic [ADDR_W-1:0]            coef_raddr;
    logic [lms_pkg::COEF_W-1:0]   coef_wdata;
    logic [lms_pkg::COEF_W-1:0]   coef_rdata;

    lms_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (samples.valid),
        .in_ready     (samples.ready),
        .out_valid    (errors.valid),
        .out_ready    (errors.ready),
        .step_size    (step_size),
        .ctl          (ctl),
        .hist_we      (hist_we),
        .hist_waddr   (hist_waddr),
        .hist_raddr   (hist_raddr),
        .coef_we      (coef_we),
        .coef_waddr   (coef_waddr),
        .coef_raddr   (coef_raddr)
    );

    lms_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk        (clk),
        .ctl        (ctl),
        .step_size  (step_size),
        .mic_sample (samples.mic_sample),
        .ref_sample (samples.ref_sample),
        .hist_rdata (hist_rdata),
        .coef_rdata (coef_rdata),
        .hist_wdata (hist_wdata),
        .coef_wdata (coef_wdata),
        .error_out  (errors.error_out)
    );

    // delay line as a circular buffer, newest sample at the write pointer
    lms_ram #(
        .WIDTH (lms_pkg::SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    lms_ram #(
        .WIDTH (lms_pkg::COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for lms_adaptive_filter, predicts every error word
// with its own fixed-point lms canceller and compares words in order on the error channel
// depends on lms_pkg, lms_if and the design files under design/

module testbench;

    localparam int     MAX_TAPS   = lms_pkg::DEF_MAX_TAPS;
    localparam int     SETTLE_CYC = 2 * MAX_TAPS + 24;
    localparam int     PHASES     = 25;
    localparam int     PHASE_LEN  = 45;
    localparam longint COEF_MAX   = 64'sd2147483647;
    localparam longint COEF_MIN   = -COEF_MAX - 1;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write_en;
    logic [lms_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lms_pkg::CFG_DATA_W-1:0] cfg_data;

    lms_sample_if samples_ch ();
    lms_error_if  errors_ch ();

    lms_adaptive_filter #(
        .MAX_TAPS(MAX_TAPS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples_ch),
        .errors       (errors_ch),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // canceller state as the bench sees it
    logic signed [lms_pkg::SAMPLE_W-1:0] far_line [MAX_TAPS];
    logic signed [lms_pkg::COEF_W-1:0]   coef_bank [MAX_TAPS];
    logic [lms_pkg::STEP_W-1:0]          mu;
    int                                  active_taps;

    logic signed [lms_pkg::SAMPLE_W-1:0] expected_errors [$];
    logic signed [lms_pkg::SAMPLE_W-1:0] sent_refs [$];
    logic signed [lms_pkg::SAMPLE_W-1:0] want_error;
    int                                  fail_count = 0;
    int                                  words_seen = 0;
    int                                  ready_hold = 0;
    bit                                  steady_mode = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_model();
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            far_line[k]  = '0;
            coef_bank[k] = '0;
        end
    endfunction

    function automatic void apply_reg_write(input logic [lms_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [lms_pkg::CFG_DATA_W-1:0] data);
        logic [lms_pkg::TAPS_W-1:0] t;
        t = data[lms_pkg::TAPS_W-1:0];
        if (idx == lms_pkg::REG_STEP_SIZE)
            mu = data[lms_pkg::STEP_W-1:0];
        else if (idx == lms_pkg::REG_TAPS_IN_USE)
        begin
            if (t == 0)
                active_taps = 1;
            else if (t > MAX_TAPS)
                active_taps = MAX_TAPS;
            else
                active_taps = t;
            clear_model();
        end
    endfunction

    function automatic logic signed [lms_pkg::SAMPLE_W-1:0] cancel_echo(
        input logic signed [lms_pkg::SAMPLE_W-1:0] mic,
        input logic signed [lms_pkg::SAMPLE_W-1:0] far);
        longint acc;
        longint est;
        longint err;
        longint delta;
        longint c;
        acc = 0;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            far_line[k] = far_line[k-1];
        far_line[0] = far;
        for (int k = 0; k < active_taps; k++)
            acc += longint'(coef_bank[k]) * longint'(far_line[k]);
        est = (acc + (longint'(1) << (lms_pkg::EST_SHIFT - 1))) >>> lms_pkg::EST_SHIFT;
        err = longint'(mic) - est;
        for (int k = 0; k < active_taps; k++)
        begin
            delta = (longint'(mu) * err * longint'(far_line[k])
                     + (longint'(1) << (lms_pkg::STEP_W - 1))) >>> lms_pkg::STEP_W;
            c = longint'(coef_bank[k]) + delta;
            if (c > COEF_MAX)
                c = COEF_MAX;
            else if (c < COEF_MIN)
                c = COEF_MIN;
            coef_bank[k] = c[lms_pkg::COEF_W-1:0];
        end
        if (err > lms_pkg::ERR_LIMIT)
            err = lms_pkg::ERR_LIMIT;
        else if (err < -lms_pkg::ERR_LIMIT)
            err = -lms_pkg::ERR_LIMIT;
        return err[lms_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic signed [lms_pkg::SAMPLE_W-1:0] want,
                                   input logic signed [lms_pkg::SAMPLE_W-1:0] got);
        $display("mismatch at error word %0d: %s, expected %0d got %0d",
                 words_seen, what, want, got);
        fail_count++;
    endtask

    task automatic send_word(input logic signed [lms_pkg::SAMPLE_W-1:0] mic,
                             input logic signed [lms_pkg::SAMPLE_W-1:0] far);
        int gap;
        samples_ch.valid      <= 1'b1;
        samples_ch.mic_sample <= mic;
        samples_ch.ref_sample <= far;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        expected_errors.push_back(cancel_echo(mic, far));
        sent_refs.push_front(far);
        if (sent_refs.size() > MAX_TAPS)
            void'(sent_refs.pop_back());
        gap = steady_mode ? 0 : pick_idle();
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [lms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lms_pkg::CFG_DATA_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        apply_reg_write(idx, data);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // drain all error words, then let the update pass finish
    task automatic settle();
        samples_ch.valid <= 1'b0;
        while (expected_errors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic test_default_config();
        send_word(16'sd32767, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768);
        send_word(16'sd0, 16'sd0);
        send_word(-16'sd32768, 16'sd32767);
        send_word(16'sd32767, -16'sd32768);
        send_word(16'sd1, -16'sd1);
    endtask

    task automatic test_tap_count_limits();
        settle();
        write_reg(lms_pkg::REG_TAPS_IN_USE, '0);
        send_word(16'sd1000, 16'sd32767);
        send_word(-16'sd32768, -16'sd32768);
        send_word(16'sd32767, 16'sd1);
        settle();
        write_reg(lms_pkg::REG_TAPS_IN_USE, 16'hffff);
        send_word(16'sd12000, -16'sd20000);
        send_word(-16'sd5000, 16'sd32767);
        settle();
        write_reg(lms_pkg::REG_TAPS_IN_USE, 16'h0002);
        send_word(16'sd32767, 16'sd32767);
        send_word(16'sd0, -16'sd32768);
        send_word(-16'sd32768, 16'sd0);
    endtask

    task automatic test_step_limits();
        settle();
        write_reg(lms_pkg::REG_STEP_SIZE, '0);
        write_reg(lms_pkg::REG_TAPS_IN_USE, 16'h0004);
        send_word(16'sd20000, 16'sd32767);
        send_word(-16'sd20000, -16'sd32768);
        send_word(16'sd7, 16'sd300);
        settle();
        write_reg(lms_pkg::REG_STEP_SIZE, 16'hffff);
        // opposite signs drive the coefficients into saturation
        for (int i = 0; i < 3; i++)
        begin
            send_word(16'sd32767, -16'sd32768);
            send_word(-16'sd32768, 16'sd32767);
        end
    endtask

    task automatic test_random_phases();
        int  r;
        int  d;
        int  shift;
        int  noise_w;
        int  v;
        bit  echo_phase;
        logic [lms_pkg::STEP_W-1:0]          step;
        logic [lms_pkg::TAPS_W-1:0]          taps;
        logic signed [lms_pkg::SAMPLE_W-1:0] far;
        logic signed [lms_pkg::SAMPLE_W-1:0] echo;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            steady_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
                step = '0;
            else if (r == 1)
                step = '1;
            else if (r < 4)
                step = lms_pkg::STEP_W'($urandom);
            else
                step = lms_pkg::STEP_W'($urandom_range(0, 8000));
            write_reg(lms_pkg::REG_STEP_SIZE, step);
            if (phase % 8 == 5)
            begin
                taps = lms_pkg::TAPS_W'($urandom_range(MAX_TAPS, 511));
                write_reg(lms_pkg::REG_TAPS_IN_USE, {7'($urandom), taps});
            end
            else if (phase == 0 || active_taps == MAX_TAPS || $urandom_range(0, 9) < 7)
            begin
                taps = ($urandom_range(0, 4) == 0)
                     ? lms_pkg::TAPS_W'($urandom_range(0, 2))
                     : lms_pkg::TAPS_W'($urandom_range(1, 24));
                write_reg(lms_pkg::REG_TAPS_IN_USE, {7'($urandom), taps});
            end
            echo_phase = ($urandom_range(0, 3) != 0);
            d       = $urandom_range(0, active_taps - 1);
            shift   = $urandom_range(0, 3);
            noise_w = $urandom_range(0, 12);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    far = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                else if (r < 6)
                    far = lms_pkg::SAMPLE_W'($urandom_range(0, 2047) - 1024);
                else
                    far = lms_pkg::SAMPLE_W'($urandom);
                if (!echo_phase || $urandom_range(0, 19) == 0)
                    send_word(lms_pkg::SAMPLE_W'($urandom), far);
                else
                begin
                    if (d == 0)
                        echo = far;
                    else if (d - 1 < sent_refs.size())
                        echo = sent_refs[d-1];
                    else
                        echo = '0;
                    v = (int'(echo) >>> shift)
                        + int'($urandom_range(0, 2 ** noise_w)) - 2 ** (noise_w - 1);
                    if (v > 32767)
                        v = 32767;
                    else if (v < -32768)
                        v = -32768;
                    send_word(lms_pkg::SAMPLE_W'(v), far);
                end
            end
        end
        steady_mode = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold = ready_hold - 1;
        else if (!steady_mode && $urandom_range(0, 99) < 30)
            ready_hold = pick_idle();
        errors_ch.ready <= (ready_hold == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && errors_ch.valid && errors_ch.ready)
        begin
            words_seen++;
            if (expected_errors.size() == 0)
                report_mismatch("word with nothing expected", '0, errors_ch.error_out);
            else
            begin
                want_error = expected_errors.pop_front();
                if (errors_ch.error_out !== want_error)
                    report_mismatch("error_out", want_error, errors_ch.error_out);
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_write_en          = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        samples_ch.valid      = 1'b0;
        samples_ch.mic_sample = '0;
        samples_ch.ref_sample = '0;
        errors_ch.ready       = 1'b0;
        mu                    = lms_pkg::STEP_W'(lms_pkg::STEP_RESET);
        active_taps           = (lms_pkg::TAPS_RESET > MAX_TAPS) ? MAX_TAPS
                                                                 : lms_pkg::TAPS_RESET;
        clear_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_config();
        test_tap_count_limits();
        test_step_limits();
        test_random_phases();
        samples_ch.valid <= 1'b0;
        while (expected_errors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
